### hdl/line_follow_pid_steering_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the line follower steering controller
// Shared property forms. Each one is clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef LINE_FOLLOW_PID_STEERING_ASSERT_SVH
`define LINE_FOLLOW_PID_STEERING_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LFPS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LFPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/lfps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfps_pkg
// Shared widths, constants and register indexes of the steering controller.
// ----------------------------------------------------------------------------
package lfps_pkg;

	localparam int TARGET_W   = 10;
	localparam int BASE_W     = 7;
	localparam int GAIN_W     = 32;
	localparam int INTEG_W    = 32;
	localparam int STEER_W    = 8;
	localparam int POWER_W    = 9;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Number of fraction bits in the gain registers.
	localparam int GAIN_FRAC_BITS = 24;

	// Steering magnitude limit.
	localparam int STEER_LIMIT = 100;

	// Magnitude cap of the integral term, 2^52, and the width that holds it signed.
	localparam int KI_CAP_W = 54;
	localparam logic signed [64:0] KI_CAP = 65'sd4503599627370496;

	// Width of the summed control effort.
	localparam int SUM_W = 56;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TARGET = 3'd0,
		REG_BASE   = 3'd1,
		REG_EDGE   = 3'd2,
		REG_KP     = 3'd3,
		REG_KI     = 3'd4,
		REG_KD     = 3'd5
	} cfg_reg_t;

endpackage

### hdl/lfps_state.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfps_state
// Error, derivative difference and saturating trapezoidal integral update.
// ----------------------------------------------------------------------------
module lfps_state #(
	parameter int SAMPLE_BITS = 10
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  accept,
	input  logic [SAMPLE_BITS-1:0]                sample,
	input  logic [lfps_pkg::TARGET_W-1:0]         target,
	output logic signed [((SAMPLE_BITS > lfps_pkg::TARGET_W) ? SAMPLE_BITS
		: lfps_pkg::TARGET_W):0]                  err_s1,
	output logic signed [((SAMPLE_BITS > lfps_pkg::TARGET_W) ? SAMPLE_BITS
		: lfps_pkg::TARGET_W)+1:0]                diff_s1,
	output logic signed [lfps_pkg::INTEG_W-1:0]   integ_s1
);
	import lfps_pkg::*;

	localparam int ERR_W = ((SAMPLE_BITS > TARGET_W) ? SAMPLE_BITS : TARGET_W) + 1;
	localparam int INC_W = ERR_W + 7;

	logic signed [ERR_W-1:0]   last_err_q;
	logic signed [INTEG_W-1:0] integ_q;
	logic signed [ERR_W-1:0]   err;
	logic signed [ERR_W:0]     pair;
	logic signed [ERR_W:0]     diff;
	logic signed [INC_W-1:0]   inc;
	logic signed [INTEG_W:0]   integ_sum;
	logic signed [INTEG_W-1:0] integ_next;

	always_comb begin
		err  = $signed(ERR_W'(target)) - $signed(ERR_W'(sample));
		pair = (ERR_W+1)'(err) + (ERR_W+1)'(last_err_q);
		diff = (ERR_W+1)'(err) - (ERR_W+1)'(last_err_q);
		// Times 50 as 32 + 16 + 2.
		inc  = (INC_W'(pair) <<< 5) + (INC_W'(pair) <<< 4) + (INC_W'(pair) <<< 1);
		integ_sum = (INTEG_W+1)'(integ_q) + (INTEG_W+1)'(inc);
		if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
			integ_next = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
				: {1'b0, {(INTEG_W-1){1'b1}}};
		end else begin
			integ_next = integ_sum[INTEG_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_err_q <= '0;
			integ_q    <= '0;
		end else if (accept) begin
			last_err_q <= err;
			integ_q    <= integ_next;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			err_s1   <= err;
			diff_s1  <= diff;
			integ_s1 <= integ_next;
		end
	end

endmodule

### hdl/lfps_mult.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfps_mult
// The three gain products, each registered.
// ----------------------------------------------------------------------------
module lfps_mult #(
	parameter int SAMPLE_BITS = 10
) (
	input  logic                                  clk,
	input  logic                                  en,
	input  logic signed [((SAMPLE_BITS > lfps_pkg::TARGET_W) ? SAMPLE_BITS
		: lfps_pkg::TARGET_W):0]                  err,
	input  logic signed [((SAMPLE_BITS > lfps_pkg::TARGET_W) ? SAMPLE_BITS
		: lfps_pkg::TARGET_W)+1:0]                diff,
	input  logic signed [lfps_pkg::INTEG_W-1:0]   integ,
	input  logic [lfps_pkg::GAIN_W-1:0]           kp_gain,
	input  logic [lfps_pkg::GAIN_W-1:0]           ki_gain,
	input  logic [lfps_pkg::GAIN_W-1:0]           kd_gain,
	output logic signed [lfps_pkg::GAIN_W+((SAMPLE_BITS > lfps_pkg::TARGET_W)
		? SAMPLE_BITS : lfps_pkg::TARGET_W)+1:0]  kp_s2,
	output logic signed [lfps_pkg::GAIN_W+lfps_pkg::INTEG_W:0] ki_s2,
	output logic signed [lfps_pkg::GAIN_W+((SAMPLE_BITS > lfps_pkg::TARGET_W)
		? SAMPLE_BITS : lfps_pkg::TARGET_W)+2:0]  kd_s2
);
	import lfps_pkg::*;

	localparam int ERR_W = ((SAMPLE_BITS > TARGET_W) ? SAMPLE_BITS : TARGET_W) + 1;
	localparam int KP_W  = GAIN_W + 1 + ERR_W;
	localparam int KD_W  = GAIN_W + 2 + ERR_W;
	localparam int KI_W  = GAIN_W + 1 + INTEG_W;

	logic signed [KP_W-1:0] kp_prod;
	logic signed [KI_W-1:0] ki_prod;
	logic signed [KD_W-1:0] kd_prod;

	// Gains are unsigned, so each gets a zero sign bit before the signed multiply.
	always_comb begin
		kp_prod = KP_W'($signed({1'b0, kp_gain})) * KP_W'(err);
		ki_prod = KI_W'($signed({1'b0, ki_gain})) * KI_W'(integ);
		kd_prod = KD_W'($signed({1'b0, kd_gain})) * KD_W'(diff);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kp_s2 <= kp_prod;
			ki_s2 <= ki_prod;
			kd_s2 <= kd_prod;
		end
	end

endmodule

### hdl/lfps_steer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfps_steer
// Sum of terms, truncation toward zero, clamping and motor power mixing.
// ----------------------------------------------------------------------------
module lfps_steer #(
	parameter int SAMPLE_BITS = 10
) (
	input  logic                                  clk,
	input  logic                                  en,
	input  logic signed [lfps_pkg::GAIN_W+((SAMPLE_BITS > lfps_pkg::TARGET_W)
		? SAMPLE_BITS : lfps_pkg::TARGET_W)+1:0]  kp_p,
	input  logic signed [lfps_pkg::GAIN_W+lfps_pkg::INTEG_W:0] ki_p,
	input  logic signed [lfps_pkg::GAIN_W+((SAMPLE_BITS > lfps_pkg::TARGET_W)
		? SAMPLE_BITS : lfps_pkg::TARGET_W)+2:0]  kd_p,
	input  logic [lfps_pkg::BASE_W-1:0]           cruise_speed,
	input  logic                                  edge_right,
	output logic signed [lfps_pkg::STEER_W-1:0]   steering,
	output logic signed [lfps_pkg::POWER_W-1:0]   left_power,
	output logic signed [lfps_pkg::POWER_W-1:0]   right_power
);
	import lfps_pkg::*;

	logic signed [KI_CAP_W-1:0] ki_c;
	logic signed [SUM_W-1:0]    sum;
	logic [SUM_W-1:0]           sum_abs;
	logic [SUM_W-1:0]           shifted;
	logic [STEER_W-2:0]         mag;
	logic signed [STEER_W-1:0]  steer;
	logic signed [STEER_W-1:0]  sgn_steer;
	logic signed [POWER_W-1:0]  base_ext;

	always_comb begin
		// A capped integral term already dwarfs the steering limit.
		if (ki_p > KI_CAP) begin
			ki_c = KI_CAP_W'(KI_CAP);
		end else if (ki_p < -KI_CAP) begin
			ki_c = KI_CAP_W'(-KI_CAP);
		end else begin
			ki_c = ki_p[KI_CAP_W-1:0];
		end
		sum     = SUM_W'(kp_p) + SUM_W'(ki_c) + SUM_W'(kd_p);
		sum_abs = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
		shifted = sum_abs >> GAIN_FRAC_BITS;
		mag     = (shifted > SUM_W'(STEER_LIMIT)) ? (STEER_W-1)'(STEER_LIMIT)
			: shifted[STEER_W-2:0];
		steer     = sum[SUM_W-1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
		sgn_steer = edge_right ? -steer : steer;
		base_ext  = $signed(POWER_W'(cruise_speed));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			steering    <= steer;
			left_power  <= base_ext + POWER_W'(sgn_steer);
			right_power <= base_ext - POWER_W'(sgn_steer);
		end
	end

endmodule

### hdl/line_follow_pid_steering.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_follow_pid_steering
// PID steering for a line follower: each green reflectance sample request
// yields one result with a clamped steering value and the left and right motor
// power. The error against the target brightness feeds a saturating
// trapezoidal integral and a derivative difference, and the three gain terms
// use unsigned Q8.24 gains. The block takes one request every clock cycle
// unless in_stall holds it off; a request passes three registers (error and
// integral stage, multiplier stage, output register). The only loop carried
// from one request to the next is the integral and previous error update,
// which completes in the cycle the request is accepted, so back to back
// samples see the fully updated state. The user must write the configuration
// registers through the cfg port while no request is in flight; the block does
// not enforce it. Writes are always taken, and unknown indexes are ignored.
// ----------------------------------------------------------------------------
`include "line_follow_pid_steering_assert.svh"
module line_follow_pid_steering #(
	parameter int SAMPLE_BITS = 10
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	// Sample request channel.
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic [SAMPLE_BITS-1:0]                  green_sample,
	// Result channel.
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic signed [lfps_pkg::STEER_W-1:0]     steering,
	output logic signed [lfps_pkg::POWER_W-1:0]     left_power,
	output logic signed [lfps_pkg::POWER_W-1:0]     right_power,
	// Configuration write channel.
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [lfps_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [lfps_pkg::CFG_DATA_W-1:0]         cfg_data
);
	import lfps_pkg::*;

	localparam int ERR_W = ((SAMPLE_BITS > TARGET_W) ? SAMPLE_BITS : TARGET_W) + 1;
	localparam int KP_W  = GAIN_W + 1 + ERR_W;
	localparam int KD_W  = GAIN_W + 2 + ERR_W;
	localparam int KI_W  = GAIN_W + 1 + INTEG_W;

	// Configuration registers.
	logic [TARGET_W-1:0] target_q;
	logic [BASE_W-1:0]   cruise_speed_q;
	logic                edge_right_q;
	logic [GAIN_W-1:0]   kp_gain_q;
	logic [GAIN_W-1:0]   ki_gain_q;
	logic [GAIN_W-1:0]   kd_gain_q;

	// Pipeline occupancy.
	logic v_s1;
	logic v_s2;
	logic out_valid_q;

	logic en1;
	logic en2;
	logic en_out;
	logic accept;

	logic signed [ERR_W-1:0]   err_s1;
	logic signed [ERR_W:0]     diff_s1;
	logic signed [INTEG_W-1:0] integ_s1;
	logic signed [KP_W-1:0]    kp_s2;
	logic signed [KI_W-1:0]    ki_s2;
	logic signed [KD_W-1:0]    kd_s2;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q       <= TARGET_W'(512);
			cruise_speed_q <= BASE_W'(50);
			edge_right_q   <= 1'b0;
			kp_gain_q      <= GAIN_W'(6039798);
			ki_gain_q      <= GAIN_W'(20132659);
			kd_gain_q      <= GAIN_W'(4530);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_TARGET: target_q       <= cfg_data[TARGET_W-1:0];
				REG_BASE:   cruise_speed_q <= cfg_data[BASE_W-1:0];
				REG_EDGE:   edge_right_q   <= cfg_data[0];
				REG_KP:     kp_gain_q      <= cfg_data[GAIN_W-1:0];
				REG_KI:     ki_gain_q      <= cfg_data[GAIN_W-1:0];
				REG_KD:     kd_gain_q      <= cfg_data[GAIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Each stage moves forward when it is empty or when the stage after it moves,
	// so bubbles close up and a full output register does not block the
	// upstream stages until they are all occupied.
	always_comb begin
		en_out = !out_valid_q || !out_stall;
		en2    = !v_s2 || en_out;
		en1    = !v_s1 || en2;
		accept = in_valid && en1;
	end

	assign in_stall  = !en1;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= in_valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en_out) begin
				out_valid_q <= v_s2;
			end
		end
	end

	lfps_state #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_state (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.sample   (green_sample),
		.target   (target_q),
		.err_s1   (err_s1),
		.diff_s1  (diff_s1),
		.integ_s1 (integ_s1)
	);

	lfps_mult #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_mult (
		.clk     (clk),
		.en      (en2),
		.err     (err_s1),
		.diff    (diff_s1),
		.integ   (integ_s1),
		.kp_gain (kp_gain_q),
		.ki_gain (ki_gain_q),
		.kd_gain (kd_gain_q),
		.kp_s2   (kp_s2),
		.ki_s2   (ki_s2),
		.kd_s2   (kd_s2)
	);

	lfps_steer #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_steer (
		.clk          (clk),
		.en           (en_out),
		.kp_p         (kp_s2),
		.ki_p         (ki_s2),
		.kd_p         (kd_s2),
		.cruise_speed (cruise_speed_q),
		.edge_right   (edge_right_q),
		.steering     (steering),
		.left_power   (left_power),
		.right_power  (right_power)
	);

	// The result never leaves the steering limit.
	`LFPS_ASSERT_NOW(a_steer_range, out_valid_q,
		(steering >= -8'sd100) && (steering <= 8'sd100), "steering out of range")

	// Left and right power are mirrored around the base speed.
	`LFPS_ASSERT_NOW(a_power_mirror, out_valid_q,
		(10'(left_power) + 10'(right_power)) == $signed({2'b00, cruise_speed_q, 1'b0}),
		"motor powers are not symmetric about base speed")

	// Requests are held off only when every stage holds an item behind a stall.
	`LFPS_ASSERT_NOW(a_stall_full, in_stall,
		v_s1 && v_s2 && out_valid_q && out_stall, "stall with room in the pipeline")

	// An accepted request occupies the first stage in the next cycle.
	`LFPS_ASSERT_NEXT(a_accept_fill, in_valid && !in_stall, v_s1,
		"accepted request did not enter the first stage")

endmodule
